// File: hw/rtl/wrps_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wrps_pkg
// Shared types, constants and control words for the weighted pool selector.
// ============================================================================
package wrps_pkg;

    localparam int DEPTH    = 1024;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int SUM_W    = 42;
    localparam int HI_W     = SUM_W - 32;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int TOTAL_W  = 11;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SELECT = 2'd1,
        OP_EMPTY  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL_LO,
        S_MUL_HI,
        S_TARGET,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_UNIFORM,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    add_write;
        logic    clear;
        logic    set_status;
        status_t status_code;
        logic    sel_ok;
        logic    mul_lo;
        logic    mul_hi;
        logic    make_target;
        logic    uniform;
        logic    search_rd;
        logic    search_cmp;
        logic    pick;
        logic    load_out;
    } wrps_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    weight_zero;
        logic    full;
        logic    empty;
        logic    weighted;
        logic    search_done;
        logic    out_free;
    } wrps_sts_t;

endpackage

// File: hw/rtl/weighted_random_pool_select.sv
`timescale 1ns / 1ps
// ============================================================================
// weighted_random_pool_select
// Pool of weighted entries with uniform or cumulative-weight random selection.
// ============================================================================
//  Channel   Handshake              Word
//  input     in_valid / in_stall    opcode, weight, item_handle, random_fraction
//  output    out_valid / out_stall  status, chosen_index, chosen_handle, entry_total
//  config    cfg_valid / cfg_ready  cfg_data (weighted mode)
//
//  Add, empty and rejected operations go from S_EXEC straight to S_DONE. Uniform
//  select passes S_UNIFORM and S_FETCH; weighted select passes S_MUL_LO, S_MUL_HI,
//  S_TARGET, a read-compare binary search loop on the RAM port, then S_FETCH.
//  Reset clears the entry count, weight sum and mode; pool RAMs are not cleared.
//  A stalled result is held while the next input word may already be accepted.
module weighted_random_pool_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [wrps_pkg::DATA_W-1:0]   weight,
    input  logic [wrps_pkg::DATA_W-1:0]   item_handle,
    input  logic [wrps_pkg::DATA_W-1:0]   random_fraction,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [wrps_pkg::INDEX_W-1:0]  chosen_index,
    output logic [wrps_pkg::DATA_W-1:0]   chosen_handle,
    output logic [wrps_pkg::TOTAL_W-1:0]  entry_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);
    import wrps_pkg::*;

    wrps_cmd_t cmd;
    wrps_sts_t sts;

    assign cfg_ready = 1'b1;

    wrps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wrps_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .weight          (weight),
        .item_handle     (item_handle),
        .random_fraction (random_fraction),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .chosen_index    (chosen_index),
        .chosen_handle   (chosen_handle),
        .entry_total     (entry_total)
    );

endmodule

// File: hw/rtl/wrps_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// wrps_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module wrps_ram #(
    parameter int WIDTH      = 32,
    parameter int ADDR_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(ADDR_DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]              wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [ADDR_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/wrps_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// wrps_ctrl
// Sequencer that steps one pool operation through the datapath.
// ============================================================================
module wrps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wrps_pkg::wrps_sts_t sts,
    output wrps_pkg::wrps_cmd_t cmd
);
    import wrps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_OK;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
                unique case (sts.op)
                    OP_ADD:
                    begin
                        priority if (sts.weight_zero)
                        begin
                            cmd.status_code = ST_ZERO;
                        end
                        else if (sts.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.add_write = 1'b1;
                        end
                    end
                    OP_SELECT:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.sel_ok = 1'b1;
                            state_next = sts.weighted ? S_MUL_LO : S_UNIFORM;
                        end
                    end
                    OP_EMPTY:
                    begin
                        cmd.clear = 1'b1;
                    end
                    OP_NOP:
                    begin
                    end
                endcase
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_TARGET;
            end
            S_TARGET:
            begin
                cmd.make_target = 1'b1;
                state_next      = S_SEARCH_RD;
            end
            S_SEARCH_RD:
            begin
                if (sts.search_done)
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.search_rd = 1'b1;
                    state_next    = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                cmd.search_cmp = 1'b1;
                state_next     = S_SEARCH_RD;
            end
            S_UNIFORM:
            begin
                cmd.uniform = 1'b1;
                state_next  = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/wrps_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// wrps_dp
// Pool storage, target scaling, search registers and output word register.
// ============================================================================
module wrps_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wrps_pkg::wrps_cmd_t             cmd,
    output wrps_pkg::wrps_sts_t             sts,
    input  logic [1:0]                      opcode,
    input  logic [wrps_pkg::DATA_W-1:0]     weight,
    input  logic [wrps_pkg::DATA_W-1:0]     item_handle,
    input  logic [wrps_pkg::DATA_W-1:0]     random_fraction,
    input  logic                            cfg_wr,
    input  logic                            cfg_data,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [1:0]                      status,
    output logic [wrps_pkg::INDEX_W-1:0]    chosen_index,
    output logic [wrps_pkg::DATA_W-1:0]     chosen_handle,
    output logic [wrps_pkg::TOTAL_W-1:0]    entry_total
);
    import wrps_pkg::*;

    logic                 mode_reg;
    logic [CW-1:0]        count_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 out_valid_reg;

    opcode_t              op_reg;
    logic [DATA_W-1:0]    weight_reg;
    logic [DATA_W-1:0]    handle_reg;
    logic [DATA_W-1:0]    frac_reg;
    status_t              status_reg;
    logic                 sel_ok_reg;
    logic [AW-1:0]        idx_reg;
    logic [63:0]          plo_reg;
    logic [SUM_W-1:0]     phi_reg;
    logic [SUM_W-1:0]     target_reg;
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [CW-1:0]        mid_reg;

    status_t              out_status_reg;
    logic [AW-1:0]        out_index_reg;
    logic [DATA_W-1:0]    out_handle_reg;
    logic [CW-1:0]        out_total_reg;

    logic [SUM_W-1:0]     sum_next;
    logic [CW-1:0]        mid;
    logic [SUM_W:0]       target_wide;
    logic [DATA_W+CW-1:0] uni_prod;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [SUM_W-1:0]     cw_rdata;
    logic [DATA_W-1:0]    h_rdata;

    assign sum_next    = sum_reg + SUM_W'(weight_reg);
    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign target_wide = (SUM_W + 1)'(phi_reg) + (SUM_W + 1)'(plo_reg[63:32])
                       + (SUM_W + 1)'(|plo_reg[31:0]);
    assign uni_prod    = (DATA_W + CW)'(frac_reg) * (DATA_W + CW)'(count_reg);
    assign ram_we      = cmd.add_write;

    always_comb
    begin
        priority if (cmd.add_write)
        begin
            ram_addr = count_reg[AW-1:0];
        end
        else if (cmd.search_rd)
        begin
            ram_addr = mid[AW-1:0];
        end
        else
        begin
            ram_addr = idx_reg;
        end
    end

    wrps_ram #(.WIDTH(SUM_W), .ADDR_DEPTH(DEPTH)) u_cw_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sum_next),
        .rdata (cw_rdata)
    );

    wrps_ram #(.WIDTH(DATA_W), .ADDR_DEPTH(DEPTH)) u_handle_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (handle_reg),
        .rdata (h_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.add_write)
            begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_next;
            end
            else if (cmd.clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode_t'(opcode);
            weight_reg <= weight;
            handle_reg <= item_handle;
            frac_reg   <= random_fraction;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
            sel_ok_reg <= cmd.sel_ok;
            idx_reg    <= '0;
        end
        else if (cmd.uniform)
        begin
            idx_reg <= uni_prod[DATA_W +: AW];
        end
        else if (cmd.pick)
        begin
            idx_reg <= (lo_reg < count_reg) ? lo_reg[AW-1:0] : '0;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= 64'(frac_reg) * 64'(sum_reg[31:0]);
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= SUM_W'(frac_reg) * SUM_W'(sum_reg[32 +: HI_W]);
        end
        if (cmd.make_target)
        begin
            target_reg <= target_wide[SUM_W-1:0];
            lo_reg     <= '0;
            hi_reg     <= count_reg;
        end
        else if (cmd.search_rd)
        begin
            mid_reg <= mid;
        end
        else if (cmd.search_cmp)
        begin
            if (cw_rdata >= target_reg)
            begin
                hi_reg <= mid_reg;
            end
            else
            begin
                lo_reg <= mid_reg + CW'(1);
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_index_reg  <= idx_reg;
            out_handle_reg <= sel_ok_reg ? h_rdata : '0;
            out_total_reg  <= count_reg;
        end
    end

    assign sts.op          = op_reg;
    assign sts.weight_zero = (weight_reg == '0);
    assign sts.full        = (count_reg == CW'(DEPTH));
    assign sts.empty       = (count_reg == '0);
    assign sts.weighted    = mode_reg;
    assign sts.search_done = !(lo_reg < hi_reg);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign chosen_index  = INDEX_W'(out_index_reg);
    assign chosen_handle = out_handle_reg;
    assign entry_total   = TOTAL_W'(out_total_reg);

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("Result word loaded over a pending word.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Entry count exceeds pool depth.");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_rd |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("Search window out of range.");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_write |=> count_reg == $past(count_reg) + CW'(1))
        else $error("Add did not advance the entry count.");

endmodule
